// ----- sv/ptf_pkg.sv -----
// ----------------------------------------------------------------------------
// ptf_pkg
// shared types and constants of the transmit framer with byte stuffing
// ----------------------------------------------------------------------------
package ptf_pkg;

  localparam logic [7:0] MarkStart = 8'h23;  // '#'
  localparam logic [7:0] MarkEsc   = 8'h3F;  // '?'
  localparam logic [7:0] EscFlip   = 8'h20;

  // packet field phase of the front, one-hot
  typedef enum logic [3:0] {
    PH_ID      = 4'b0001,
    PH_LEN_LO  = 4'b0010,
    PH_LEN_HI  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  // one classified input byte, handed from front to back
  typedef struct packed {
    logic       start;    // send the start marker first
    logic [7:0] data;     // packet byte, unstuffed
    logic       ck_en;    // checksum follows this byte
    logic [7:0] ck;       // checksum value, unstuffed
  } entry_t;

  function automatic logic needs_esc(input logic [7:0] b);
    needs_esc = (b == MarkEsc) || (b == MarkStart);
  endfunction

endpackage

// ----- sv/ptf_front.sv -----
// ----------------------------------------------------------------------------
// ptf_front
// tracks the packet fields, keeps the running sum, classifies each byte
// ----------------------------------------------------------------------------
module ptf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  output ptf_pkg::entry_t   entry_o
);

  ptf_pkg::phase_e phase_q, phase_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [15:0]     remain_q, remain_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      sum_add;

  assign sum_add = sum_q + data_byte_i;

  always_comb begin
    phase_d        = phase_q;
    len_lo_d       = len_lo_q;
    remain_d       = remain_q;
    sum_d          = sum_add;
    entry_o.start  = 1'b0;
    entry_o.data   = data_byte_i;
    entry_o.ck_en  = 1'b0;
    entry_o.ck     = 8'h00 - sum_add;
    unique case (phase_q)
      ptf_pkg::PH_ID: begin
        sum_d         = data_byte_i;
        entry_o.start = 1'b1;
        phase_d       = ptf_pkg::PH_LEN_LO;
      end
      ptf_pkg::PH_LEN_LO: begin
        len_lo_d = data_byte_i;
        phase_d  = ptf_pkg::PH_LEN_HI;
      end
      ptf_pkg::PH_LEN_HI: begin
        remain_d = {data_byte_i, len_lo_q};
        if (remain_d == 16'h0000) begin
          entry_o.ck_en = 1'b1;
          phase_d       = ptf_pkg::PH_ID;
        end else begin
          phase_d = ptf_pkg::PH_PAYLOAD;
        end
      end
      ptf_pkg::PH_PAYLOAD: begin
        remain_d = remain_q - 16'h0001;
        if (remain_d == 16'h0000) begin
          entry_o.ck_en = 1'b1;
          phase_d       = ptf_pkg::PH_ID;
        end
      end
      default: begin
        phase_d = ptf_pkg::PH_ID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ptf_pkg::PH_ID;
      len_lo_q <= 8'h00;
      remain_q <= 16'h0000;
      sum_q    <= 8'h00;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      len_lo_q <= len_lo_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
    end
  end

endmodule

// ----- sv/ptf_queue.sv -----
// ----------------------------------------------------------------------------
// ptf_queue
// short fifo of classified entries between front and back
// ----------------------------------------------------------------------------
module ptf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptf_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ptf_pkg::entry_t rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  ptf_pkg::entry_t        mem_q [DEPTH];
  logic [PtrW-1:0]        wptr_q, rptr_q;
  logic [CntW-1:0]        cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- sv/ptf_back.sv -----
// ----------------------------------------------------------------------------
// ptf_back
// expands one entry into link beats and holds them in the output register
// ----------------------------------------------------------------------------
module ptf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ptf_pkg::entry_t entry_i,
  output logic            pop_o,
  input  logic            out_pop_i,
  output logic            empty_o,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            packet_end_o
);

  typedef enum logic [4:0] {
    ST_START   = 5'b00001,
    ST_DAT_ESC = 5'b00010,
    ST_DAT     = 5'b00100,
    ST_CK_ESC  = 5'b01000,
    ST_CK      = 5'b10000
  } step_e;

  // progress through the current entry
  logic       start_done_q, desc_done_q, dat_done_q, cesc_done_q;
  step_e      step;
  logic       emit, last;
  logic [7:0] beat_byte;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q, out_end_q;

  always_comb begin
    priority if (entry_i.start && !start_done_q) begin
      step = ST_START;
    end else if (ptf_pkg::needs_esc(entry_i.data) && !desc_done_q) begin
      step = ST_DAT_ESC;
    end else if (!dat_done_q) begin
      step = ST_DAT;
    end else if (ptf_pkg::needs_esc(entry_i.ck) && !cesc_done_q) begin
      step = ST_CK_ESC;
    end else begin
      step = ST_CK;
    end
  end

  always_comb begin
    unique case (step)
      ST_START:   beat_byte = ptf_pkg::MarkStart;
      ST_DAT_ESC: beat_byte = ptf_pkg::MarkEsc;
      ST_DAT: begin
        beat_byte = ptf_pkg::needs_esc(entry_i.data) ?
                    (entry_i.data ^ ptf_pkg::EscFlip) : entry_i.data;
      end
      ST_CK_ESC:  beat_byte = ptf_pkg::MarkEsc;
      ST_CK: begin
        beat_byte = ptf_pkg::needs_esc(entry_i.ck) ?
                    (entry_i.ck ^ ptf_pkg::EscFlip) : entry_i.ck;
      end
      default:    beat_byte = ptf_pkg::MarkStart;
    endcase
  end

  assign last  = ((step == ST_DAT) && !entry_i.ck_en) || (step == ST_CK);
  assign emit  = valid_i && (!out_valid_q || out_pop_i);
  assign pop_o = emit && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_done_q <= 1'b0;
      desc_done_q  <= 1'b0;
      dat_done_q   <= 1'b0;
      cesc_done_q  <= 1'b0;
    end else if (emit) begin
      if (last) begin
        start_done_q <= 1'b0;
        desc_done_q  <= 1'b0;
        dat_done_q   <= 1'b0;
        cesc_done_q  <= 1'b0;
      end else begin
        unique case (step)
          ST_START:   start_done_q <= 1'b1;
          ST_DAT_ESC: desc_done_q  <= 1'b1;
          ST_DAT:     dat_done_q   <= 1'b1;
          ST_CK_ESC:  cesc_done_q  <= 1'b1;
          default:    cesc_done_q  <= cesc_done_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= beat_byte;
      out_last_q <= last;
      out_end_q  <= (step == ST_CK);
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;
  assign packet_end_o  = out_end_q;

endmodule

// ----- sv/packet_tx_framer_stuffing_core.sv -----
// ----------------------------------------------------------------------------
// packet_tx_framer_stuffing_core
// transmit framer: start marker, byte stuffing and sum checksum on a link
// ----------------------------------------------------------------------------
// path: an accepted byte is written into the entry queue, and its first beat
//   into the output register once the queue ahead is empty and output free
// throughput: one link beat per cycle while pop is high; an input byte makes
//   1 to 4 beats, and the back expander paces the input once the queue fills
// input keeps being taken while the entry queue (QDEPTH deep) has room
// reset: asynchronous active low; phase back to id, sum and count cleared,
//   queue and output register emptied
module packet_tx_framer_stuffing_core #(
  parameter int unsigned QDEPTH = 4   // entries between front and back, >= 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       packet_end_o
);

  ptf_pkg::entry_t front_entry;   // classified byte from the front
  ptf_pkg::entry_t head_entry;    // oldest entry waiting for the back
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            accept;

  // an input beat goes in whenever the entry queue has a free slot
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: field phase, length latch, payload count and running sum
  ptf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .entry_o     (front_entry)
  );

  // short queue decoupling classification from the beat expansion
  ptf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (head_entry)
  );

  // back: walks marker, escapes, data and checksum one beat a cycle while
  // pop is high; the output register lets the next beat form while one waits
  ptf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (head_entry),
    .pop_o         (q_pop),
    .out_pop_i     (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .packet_end_o  (packet_end_o)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the transmit framer with byte stuffing and checksum
// ----------------------------------------------------------------------------
// packets of id, length and payload bytes go in through the push side, and
// every link beat that comes out is checked against a software framer that
// runs alongside; a short table of hand-picked bytes comes first, then
// random packets, mostly short, with stuffed bytes and stuffed checksums
// forced often
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RandItems  = 448;   // random input bytes after the table
  localparam int unsigned QuietLimit = 2000;  // cycles with no beat on either side
  localparam int unsigned DrainWait  = 20;    // settle time after the last beat
  localparam int unsigned MaxReports = 10;

  // one link beat: {out_byte, last_of_run, packet_end}
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       packet_end;
  } beat_t;

  // one row of the directed table; n_typed == 0 leaves the beats to the
  // software framer, otherwise the typed beats are what must come out
  typedef struct packed {
    logic [7:0]      data;
    logic [2:0]      n_typed;
    beat_t [3:0]     typed;
  } row_t;

  // dut ports
  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] data_byte_i = 8'h00;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       packet_end_o;

  packet_tx_framer_stuffing_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .packet_end_o  (packet_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // software framer: its own copy of phase, length and running sum
  // --------------------------------------------------------------------------
  ptf_pkg::phase_e frame_phase = ptf_pkg::PH_ID;
  logic [7:0]  frame_len_lo = 8'h00;
  logic [15:0] frame_left = 16'h0000;
  logic [7:0]  frame_sum = 8'h00;
  beat_t       frame_beats[$];   // beats caused by the byte just framed
  beat_t       link_expect[$];   // beats still owed by the dut, oldest first

  // run statistics
  int unsigned n_errors = 0;
  int unsigned n_in = 0;
  int unsigned n_beats = 0;
  int unsigned n_packets = 0;
  int unsigned n_stuffed_ck = 0;
  int unsigned longest_payload = 0;

  function void emit_raw(input logic [7:0] b, input logic pend);
    beat_t bt;
    bt.out_byte    = b;
    bt.last_of_run = 1'b0;
    bt.packet_end  = pend;
    frame_beats.push_back(bt);
  endfunction

  // escape byte first, then the flipped byte, for a marker value; else the byte as is
  function void emit_stuffed(input logic [7:0] b, input logic pend);
    if (b == ptf_pkg::MarkEsc || b == ptf_pkg::MarkStart) begin
      emit_raw(ptf_pkg::MarkEsc, 1'b0);
      emit_raw(b ^ ptf_pkg::EscFlip, pend);
    end else begin
      emit_raw(b, pend);
    end
  endfunction

  function void emit_checksum();
    logic [7:0] ck;
    ck = 8'h00 - frame_sum;
    if (ck == ptf_pkg::MarkEsc || ck == ptf_pkg::MarkStart) n_stuffed_ck++;
    emit_stuffed(ck, 1'b1);
    frame_phase = ptf_pkg::PH_ID;
    n_packets++;
  endfunction

  function void frame_byte(input logic [7:0] b);
    frame_beats.delete();
    case (frame_phase)
      ptf_pkg::PH_ID: begin
        frame_sum = b;
        emit_raw(ptf_pkg::MarkStart, 1'b0);
        emit_stuffed(b, 1'b0);
        frame_phase = ptf_pkg::PH_LEN_LO;
      end
      ptf_pkg::PH_LEN_LO: begin
        frame_sum    = frame_sum + b;
        frame_len_lo = b;
        emit_stuffed(b, 1'b0);
        frame_phase = ptf_pkg::PH_LEN_HI;
      end
      ptf_pkg::PH_LEN_HI: begin
        frame_sum  = frame_sum + b;
        frame_left = {b, frame_len_lo};
        emit_stuffed(b, 1'b0);
        // zero length: checksum right behind the length
        if (frame_left == 16'h0000) emit_checksum();
        else frame_phase = ptf_pkg::PH_PAYLOAD;
      end
      default: begin
        frame_sum  = frame_sum + b;
        frame_left = frame_left - 16'd1;
        emit_stuffed(b, 1'b0);
        if (frame_left == 16'h0000) emit_checksum();
      end
    endcase
    frame_beats[frame_beats.size() - 1].last_of_run = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // idle patterns: mostly short gaps, a few long ones, and calm stretches
  // --------------------------------------------------------------------------
  bit push_calm = 1'b0;
  bit pop_calm  = 1'b0;

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // --------------------------------------------------------------------------
  // push side
  // --------------------------------------------------------------------------
  // drive one byte until it is taken, then line up the beats it owes
  task automatic feed_byte(input logic [7:0] b, input int unsigned n_typed,
                           input beat_t [3:0] typed);
    int unsigned gap;
    if ($urandom_range(0, 99) < 3) push_calm = !push_calm;
    gap = pick_gap(push_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    n_in++;
    frame_byte(b);
    if (n_typed > 0) begin
      for (int i = 0; i < n_typed; i++) link_expect.push_back(typed[i]);
    end else begin
      foreach (frame_beats[i]) link_expect.push_back(frame_beats[i]);
    end
  endtask

  row_t dir_rows[$];

  task automatic add_row(input logic [7:0] d, input int unsigned n = 0,
                         input beat_t b0 = '0, input beat_t b1 = '0,
                         input beat_t b2 = '0, input beat_t b3 = '0);
    row_t r;
    r.data     = d;
    r.n_typed  = 3'(n);
    r.typed[0] = b0;
    r.typed[1] = b1;
    r.typed[2] = b2;
    r.typed[3] = b3;
    dir_rows.push_back(r);
  endtask

  // payload bytes lean toward the markers and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return ptf_pkg::MarkStart;
      1:       return ptf_pkg::MarkEsc;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // builds one packet; sometimes one byte is bent so the checksum needs stuffing
  task automatic send_packet(input logic [15:0] len, input bit bend_ck);
    logic [7:0]  pkt[$];
    logic [7:0]  want_ck;
    logic [7:0]  rest;
    int unsigned adj;
    pkt.push_back(pick_byte());
    pkt.push_back(len[7:0]);
    pkt.push_back(len[15:8]);
    for (int unsigned i = 0; i < len; i++) pkt.push_back(pick_byte());
    if (bend_ck) begin
      want_ck = $urandom_range(0, 1) ? ptf_pkg::MarkStart : ptf_pkg::MarkEsc;
      adj = (len == 16'h0000) ? 0 : pkt.size() - 1;
      rest = 8'h00;
      foreach (pkt[i]) if (i != adj) rest = rest + pkt[i];
      pkt[adj] = 8'h00 - want_ck - rest;
    end
    if (len > longest_payload) longest_payload = len;
    foreach (pkt[i]) feed_byte(pkt[i], 0, '0);
  endtask

  initial begin
    int unsigned rand_start;
    int unsigned r;
    logic [15:0] len;

    // all-zero packet of zero length straight after reset
    add_row(8'h00, 2, {8'h23, 2'b00}, {8'h00, 2'b10});
    add_row(8'h00, 1, {8'h00, 2'b10});
    add_row(8'h00, 2, {8'h00, 2'b00}, {8'h00, 2'b11});
    // all-ones id, one all-ones payload byte
    add_row(8'hFF, 2, {8'h23, 2'b00}, {8'hFF, 2'b10});
    add_row(8'h01);
    add_row(8'h00);
    add_row(8'hFF);
    // start marker as id, escape and flip value in the payload
    add_row(8'h23, 3, {8'h23, 2'b00}, {8'h3F, 2'b00}, {8'h03, 2'b10});
    add_row(8'h02);
    add_row(8'h00);
    add_row(8'h3F);
    add_row(8'h20);
    // stuffed last payload byte and stuffed checksum: four beats from one byte
    add_row(8'h9D);
    add_row(8'h01);
    add_row(8'h00);
    add_row(8'h23, 4, {8'h3F, 2'b00}, {8'h03, 2'b00}, {8'h3F, 2'b00},
            {8'h1F, 2'b11});
    // zero length with a checksum equal to the start marker
    add_row(8'hDD);
    add_row(8'h00);
    add_row(8'h00, 3, {8'h00, 2'b00}, {8'h3F, 2'b00}, {8'h03, 2'b11});
    // escape byte as id of a zero-length packet
    add_row(8'h3F, 3, {8'h23, 2'b00}, {8'h3F, 2'b00}, {8'h1F, 2'b10});
    add_row(8'h00);
    add_row(8'h00);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) feed_byte(dir_rows[i].data, dir_rows[i].n_typed, dir_rows[i].typed);

    // random packets, mostly short, a few of medium length
    rand_start = n_in;
    while (n_in - rand_start < RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len = 16'($urandom_range(0, 4));
      else if (r < 95) len = 16'($urandom_range(5, 16));
      else             len = 16'($urandom_range(17, 48));
      send_packet(len, $urandom_range(0, 99) < 15);
    end
    push <= 1'b0;

    // drain, then give stray beats a chance to show up
    while (link_expect.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("framed %0d input bytes in %0d packets, longest payload %0d bytes",
             n_in, n_packets, longest_payload);
    $display("checked %0d link beats, %0d packets closed by a stuffed checksum",
             n_beats, n_stuffed_ck);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // pop side: random stalls, with calm stretches where pop stays high
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 99) < 3) pop_calm = !pop_calm;
      stall = pick_gap(pop_calm);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // link beat checker
  // --------------------------------------------------------------------------
  beat_t seen_beat;
  beat_t owed_beat;

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      seen_beat = {out_byte_o, last_of_run_o, packet_end_o};
      n_beats++;
      if (link_expect.size() == 0) begin
        note_error($sformatf("unexpected beat: byte %02h last %0b end %0b",
                             seen_beat.out_byte, seen_beat.last_of_run,
                             seen_beat.packet_end));
      end else begin
        owed_beat = link_expect.pop_front();
        if (seen_beat.out_byte    !== owed_beat.out_byte ||
            seen_beat.last_of_run !== owed_beat.last_of_run ||
            seen_beat.packet_end  !== owed_beat.packet_end) begin
          note_error($sformatf(
            "beat %0d: want byte %02h last %0b end %0b, got byte %02h last %0b end %0b",
            n_beats, owed_beat.out_byte, owed_beat.last_of_run, owed_beat.packet_end,
            seen_beat.out_byte, seen_beat.last_of_run, seen_beat.packet_end));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without a beat on either side ends the run
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("timeout: no beat for %0d cycles, %0d beats still owed",
                 QuietLimit, link_expect.size());
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ----- files.f -----
sv/ptf_pkg.sv
sv/ptf_front.sv
sv/ptf_queue.sv
sv/ptf_back.sv
sv/packet_tx_framer_stuffing_core.sv
tb/tb.sv
